[rtl/psd_pkg.sv]
package psd_pkg;

  // Build constants of the decoder.
  localparam int ADDR_BITS   = 32;
  localparam int FIELD_BYTES = 8;

  // Field values may use at most this many bits.
  localparam int AW_BITS = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam logic [31:0] AW_MASK =
    (AW_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << AW_BITS) - 64'd1);
  localparam logic [2:0] LAST_FIELD_BYTE = 3'(FIELD_BYTES - 1);

  // Record type bytes.
  localparam logic [7:0] TYPE_COPY   = 8'h43;
  localparam logic [7:0] TYPE_INSERT = 8'h49;
  localparam logic [7:0] TYPE_REPEAT = 8'h52;

  // Result queue.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Configuration port: one 32-bit register, word index in paddr[2].
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-3:0] REG_OLD_SIZE = '0;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_TYPE,
    PH_C_DEST,
    PH_C_BEGIN,
    PH_C_END,
    PH_I_DEST,
    PH_I_LEN,
    PH_I_DATA,
    PH_R_DEST,
    PH_R_AMOUNT,
    PH_R_VALUE,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_COPY,
    CMD_FILL,
    CMD_DONE,
    CMD_MALFORMED
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   command_kind;
    logic [31:0] dest_addr;
    logic [31:0] src_addr;
    logic [31:0] run_length;
    logic [7:0]  data_byte;
    logic [31:0] new_size;
    logic [31:0] record_count;
    logic        final_result;
  } psd_result_t;

  // What the parser hands to the result queue for one accepted byte.
  typedef struct packed {
    logic        cmd_v;
    cmd_kind_t   kind;
    logic [31:0] dest;
    logic [31:0] src;
    logic [31:0] room;
    logic [31:0] span_a;
    logic [31:0] span_b;
    logic [7:0]  data;
    logic        fin_v;
    logic        fin_done;
    logic [31:0] new_size;
    logic [31:0] record_count;
  } psd_event_t;

  function automatic logic [31:0] span(input logic [31:0] from, input logic [31:0] limit);
    span = (from < limit) ? (limit - from) : 32'd0;
  endfunction

endpackage

[rtl/psd_if.sv]
interface psd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] patch_byte;
  logic       last_byte;

  modport source (output valid, output patch_byte, output last_byte, input ready);
  modport sink   (input valid, input patch_byte, input last_byte, output ready);
endinterface

interface psd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command_kind;
  logic [31:0] dest_addr;
  logic [31:0] src_addr;
  logic [31:0] run_length;
  logic [7:0]  data_byte;
  logic [31:0] new_size;
  logic [31:0] record_count;
  logic        final_result;

  modport source (output valid, output command_kind, output dest_addr, output src_addr,
                  output run_length, output data_byte, output new_size,
                  output record_count, output final_result, input ready);
  modport sink   (input valid, input command_kind, input dest_addr, input src_addr,
                  input run_length, input data_byte, input new_size,
                  input record_count, input final_result, output ready);
endinterface

[rtl/psd_cfg_regs.sv]
module psd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [psd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [31:0]                old_size
);
  import psd_pkg::*;

  logic [31:0] old_size_r;
  logic        wr_en;
  logic        sel_old_size;

  assign sel_old_size = (paddr[PADDR_W-1:2] == REG_OLD_SIZE);
  assign wr_en        = psel && penable && pwrite;
  assign pready       = 1'b1;
  assign prdata       = sel_old_size ? old_size_r : 32'd0;
  assign old_size     = old_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_size_r <= 32'd0;
    end else if (wr_en && sel_old_size) begin
      old_size_r <= pwdata;
    end
  end

endmodule

[rtl/psd_parser.sv]
module psd_parser (
  input  logic                clk,
  input  logic                rst_n,
  psd_in_if.sink              in_stream,
  input  logic [31:0]         old_size,
  input  logic                take,
  output psd_pkg::psd_event_t ev,
  output logic                ev_valid
);
  import psd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt;
  logic [2:0]  bif_r, bif_nxt;
  logic [31:0] target_r, target_nxt;
  logic [31:0] dest_r, dest_nxt;
  logic [31:0] room_r, room_nxt;
  logic [31:0] second_r, second_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [31:0] records_r, records_nxt;

  psd_event_t  ev_r, ev_nxt;
  logic        ev_v_r;

  logic        accept;
  logic [7:0]  b;
  logic [63:0] wide;
  logic        fld_ovf;
  logic [31:0] fld_val;
  logic        fld_done;
  logic        feeding;

  assign in_stream.ready = take || !ev_v_r;
  assign accept          = in_stream.valid && in_stream.ready;
  assign b               = in_stream.patch_byte;
  assign ev              = ev_r;
  assign ev_valid        = ev_v_r;

  // Field assembly: each byte lands at its little-endian position; any bit
  // above the address width marks the field as too wide.
  assign wide     = 64'(b) << {bif_r, 3'b000};
  assign fld_ovf  = ovf_r | (|(wide >> AW_BITS));
  assign fld_val  = acc_r | (wide[31:0] & AW_MASK);
  assign fld_done = (bif_r == LAST_FIELD_BYTE);

  always_comb begin
    feeding = (phase_r == PH_HEADER) || (phase_r == PH_C_DEST) ||
              (phase_r == PH_C_BEGIN) || (phase_r == PH_C_END) ||
              (phase_r == PH_I_DEST) || (phase_r == PH_I_LEN) ||
              (phase_r == PH_R_DEST) || (phase_r == PH_R_AMOUNT);
  end

  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    ovf_nxt     = ovf_r;
    bif_nxt     = bif_r;
    target_nxt  = target_r;
    dest_nxt    = dest_r;
    room_nxt    = room_r;
    second_nxt  = second_r;
    remain_nxt  = remain_r;
    records_nxt = records_r;
    ev_nxt      = '0;
    ev_nxt.kind = CMD_WRITE;

    if (feeding) begin
      if (fld_done) begin
        acc_nxt = 32'd0;
        ovf_nxt = 1'b0;
        bif_nxt = 3'd0;
      end else begin
        acc_nxt = fld_val;
        ovf_nxt = fld_ovf;
        bif_nxt = bif_r + 3'd1;
      end
    end

    unique case (phase_r)
      PH_HEADER: begin
        if (fld_done) begin
          if (fld_ovf) begin
            phase_nxt = PH_ERROR;
          end else begin
            target_nxt = fld_val;
            phase_nxt  = PH_TYPE;
          end
        end
      end
      PH_TYPE: begin
        if (b == TYPE_COPY) begin
          phase_nxt = PH_C_DEST;
        end else if (b == TYPE_INSERT) begin
          phase_nxt = PH_I_DEST;
        end else if (b == TYPE_REPEAT) begin
          phase_nxt = PH_R_DEST;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_C_DEST, PH_I_DEST, PH_R_DEST: begin
        if (fld_done) begin
          if (fld_ovf) begin
            phase_nxt = PH_ERROR;
          end else begin
            dest_nxt = fld_val;
            // Bytes left before the new size, kept for clipping and for
            // dropping insert writes.
            room_nxt = span(fld_val, target_r);
            if (phase_r == PH_C_DEST) begin
              phase_nxt = PH_C_BEGIN;
            end else if (phase_r == PH_I_DEST) begin
              phase_nxt = PH_I_LEN;
            end else begin
              phase_nxt = PH_R_AMOUNT;
            end
          end
        end
      end
      PH_C_BEGIN, PH_R_AMOUNT: begin
        if (fld_done) begin
          if (fld_ovf) begin
            phase_nxt = PH_ERROR;
          end else begin
            second_nxt = fld_val;
            phase_nxt  = (phase_r == PH_C_BEGIN) ? PH_C_END : PH_R_VALUE;
          end
        end
      end
      PH_C_END: begin
        if (fld_done) begin
          if (fld_ovf) begin
            phase_nxt = PH_ERROR;
          end else begin
            ev_nxt.cmd_v  = 1'b1;
            ev_nxt.kind   = CMD_COPY;
            ev_nxt.dest   = dest_r;
            ev_nxt.src    = second_r;
            ev_nxt.room   = room_r;
            ev_nxt.span_a = span(second_r, fld_val);
            ev_nxt.span_b = span(second_r, old_size);
            records_nxt   = records_r + 32'd1;
            phase_nxt     = PH_TYPE;
          end
        end
      end
      PH_I_LEN: begin
        if (fld_done) begin
          if (fld_ovf) begin
            phase_nxt = PH_ERROR;
          end else begin
            remain_nxt = fld_val;
            if (fld_val == 32'd0) begin
              records_nxt = records_r + 32'd1;
              phase_nxt   = PH_TYPE;
            end else begin
              phase_nxt = PH_I_DATA;
            end
          end
        end
      end
      PH_I_DATA: begin
        // Once the room runs out the position no longer matters: every
        // later byte of the record is dropped.
        if (room_r != 32'd0) begin
          ev_nxt.cmd_v = 1'b1;
          ev_nxt.kind  = CMD_WRITE;
          ev_nxt.dest  = dest_r;
          ev_nxt.data  = b;
          dest_nxt     = dest_r + 32'd1;
          room_nxt     = room_r - 32'd1;
        end
        remain_nxt = remain_r - 32'd1;
        if (remain_r == 32'd1) begin
          records_nxt = records_r + 32'd1;
          phase_nxt   = PH_TYPE;
        end
      end
      PH_R_VALUE: begin
        ev_nxt.cmd_v  = 1'b1;
        ev_nxt.kind   = CMD_FILL;
        ev_nxt.dest   = dest_r;
        ev_nxt.data   = b;
        ev_nxt.room   = room_r;
        ev_nxt.span_a = second_r;
        ev_nxt.span_b = 32'hFFFF_FFFF;
        records_nxt   = records_r + 32'd1;
        phase_nxt     = PH_TYPE;
      end
      PH_ERROR: begin
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase

    if (in_stream.last_byte) begin
      ev_nxt.fin_v        = 1'b1;
      ev_nxt.fin_done     = (phase_nxt == PH_TYPE);
      ev_nxt.new_size     = (phase_nxt == PH_TYPE) ? target_nxt : 32'd0;
      ev_nxt.record_count = records_nxt;
      phase_nxt   = PH_HEADER;
      acc_nxt     = 32'd0;
      ovf_nxt     = 1'b0;
      bif_nxt     = 3'd0;
      target_nxt  = 32'd0;
      dest_nxt    = 32'd0;
      room_nxt    = 32'd0;
      second_nxt  = 32'd0;
      remain_nxt  = 32'd0;
      records_nxt = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      acc_r     <= 32'd0;
      ovf_r     <= 1'b0;
      bif_r     <= 3'd0;
      target_r  <= 32'd0;
      dest_r    <= 32'd0;
      room_r    <= 32'd0;
      second_r  <= 32'd0;
      remain_r  <= 32'd0;
      records_r <= 32'd0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      ovf_r     <= ovf_nxt;
      bif_r     <= bif_nxt;
      target_r  <= target_nxt;
      dest_r    <= dest_nxt;
      room_r    <= room_nxt;
      second_r  <= second_nxt;
      remain_r  <= remain_nxt;
      records_r <= records_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_v_r <= 1'b0;
    end else if (in_stream.ready) begin
      ev_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.ready) begin
      ev_r <= ev_nxt;
    end
  end

endmodule

[rtl/psd_out_queue.sv]
module psd_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  psd_pkg::psd_event_t ev,
  input  logic                ev_valid,
  output logic                take,
  psd_out_if.source           out_stream
);
  import psd_pkg::*;

  psd_result_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wp_r, rp_r;
  logic [QCNT_W-1:0]       count_r, count_nxt;

  psd_result_t             cmd_res, fin_res, head;
  logic [31:0]             min_ab, run;
  logic                    push, pop;
  logic [QCNT_W-1:0]       n_push;
  logic [QPTR_W-1:0]       wp_fin;

  // Clipped run: the smallest of the destination room and both source
  // limits. Writes carry zero room, fills an open second limit.
  assign min_ab = (ev.span_a < ev.span_b) ? ev.span_a : ev.span_b;
  assign run    = (ev.room < min_ab) ? ev.room : min_ab;

  always_comb begin
    cmd_res              = '0;
    cmd_res.command_kind = ev.kind;
    cmd_res.dest_addr    = ev.dest;
    cmd_res.src_addr     = ev.src;
    cmd_res.run_length   = run;
    cmd_res.data_byte    = ev.data;

    fin_res              = '0;
    fin_res.command_kind = ev.fin_done ? CMD_DONE : CMD_MALFORMED;
    fin_res.new_size     = ev.new_size;
    fin_res.record_count = ev.record_count;
    fin_res.final_result = 1'b1;
  end

  // Room for two entries is checked on the registered count alone, so the
  // input side never waits on the output handshake combinationally.
  assign take   = (count_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign push   = ev_valid && take;
  assign pop    = out_stream.valid && out_stream.ready;
  assign n_push = push ? (QCNT_W'(ev.cmd_v) + QCNT_W'(ev.fin_v)) : '0;
  assign wp_fin = wp_r + QPTR_W'(ev.cmd_v);

  assign count_nxt = count_r + n_push - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_r + n_push[QPTR_W-1:0];
      rp_r    <= rp_r + QPTR_W'(pop);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && ev.cmd_v) begin
      mem_r[wp_r] <= cmd_res;
    end
    if (push && ev.fin_v) begin
      mem_r[wp_fin] <= fin_res;
    end
  end

  assign head = mem_r[rp_r];

  assign out_stream.valid        = (count_r != '0);
  assign out_stream.command_kind = head.command_kind;
  assign out_stream.dest_addr    = head.dest_addr;
  assign out_stream.src_addr     = head.src_addr;
  assign out_stream.run_length   = head.run_length;
  assign out_stream.data_byte    = head.data_byte;
  assign out_stream.new_size     = head.new_size;
  assign out_stream.record_count = head.record_count;
  assign out_stream.final_result = head.final_result;

endmodule

[rtl/patch_stream_command_decoder.sv]
// Channel      Role    Moves per transaction
// in_stream    sink    patch_byte, last_byte
// out_stream   source  command_kind, dest_addr, src_addr, run_length, data_byte,
//                      new_size, record_count, final_result
// psel/paddr   APB     old_size at byte address 0, write and read back
//
// One patch byte is accepted every cycle while in_stream.ready is high; its results
// are registered and queued and leave one per cycle while out_stream.ready is high.
// A last byte may produce two results; the four-entry result queue absorbs them.
// in_stream.ready drops only while the queue holds more than two results.
// rst_n is synchronous and returns the parser to the header and old_size to zero.
module patch_stream_command_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  psd_in_if.sink                      in_stream,
  psd_out_if.source                   out_stream,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import psd_pkg::*;

  logic [31:0] old_size;
  psd_event_t  ev;
  logic        ev_valid;
  logic        take;

  psd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .old_size (old_size)
  );

  psd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .old_size  (old_size),
    .take      (take),
    .ev        (ev),
    .ev_valid  (ev_valid)
  );

  psd_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .ev         (ev),
    .ev_valid   (ev_valid),
    .take       (take),
    .out_stream (out_stream)
  );

endmodule

[rtl/psd_checker.sv]
module psd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  command_kind,
  input logic [31:0] dest_addr,
  input logic [31:0] src_addr,
  input logic [31:0] run_length,
  input logic [31:0] new_size,
  input logic [31:0] record_count,
  input logic        final_result
);
  import psd_pkg::*;

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(command_kind) && $stable(dest_addr) &&
      $stable(run_length) && $stable(record_count))
    else $error("result payload changed while stalled");

  a_final_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> final_result == (command_kind == CMD_DONE ||
                                   command_kind == CMD_MALFORMED))
    else $error("final_result does not match the result kind");

  a_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && command_kind == CMD_WRITE |->
      run_length == 32'd0 && src_addr == 32'd0 && new_size == 32'd0)
    else $error("write transaction carries range or size fields");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result queue not empty after reset");

endmodule

bind patch_stream_command_decoder psd_checker u_psd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_stream.valid),
  .out_ready    (out_stream.ready),
  .command_kind (out_stream.command_kind),
  .dest_addr    (out_stream.dest_addr),
  .src_addr     (out_stream.src_addr),
  .run_length   (out_stream.run_length),
  .new_size     (out_stream.new_size),
  .record_count (out_stream.record_count),
  .final_result (out_stream.final_result)
);
